[sv/tpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the trace-context header parser.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;
    localparam logic [POS_W-1:0] WIRE_LEN       = 6'd55;
    localparam logic [POS_W-1:0] POS_LAST       = 6'd54;
    localparam logic [POS_W-1:0] POS_DASH_VER   = 6'd2;
    localparam logic [POS_W-1:0] POS_DASH_TRACE = 6'd35;
    localparam logic [POS_W-1:0] POS_DASH_PAR   = 6'd52;
    localparam logic [POS_W-1:0] POS_VER_END    = 6'd1;
    localparam logic [POS_W-1:0] POS_TRH_END    = 6'd18;
    localparam logic [POS_W-1:0] POS_TRL_END    = 6'd34;
    localparam logic [POS_W-1:0] POS_PAR_END    = 6'd51;

    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam logic [7:0] VER_STRICT = 8'h00;
    localparam logic [7:0] VER_BANNED = 8'hff;

    typedef struct packed {
        logic       is_dash;
        logic       is_hex;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        logic        valid_res;
        logic [7:0]  version;
        logic [63:0] trace_id_high;
        logic [63:0] trace_id_low;
        logic [63:0] span_id;
        logic [7:0]  flag_bits;
    } result_t;

endpackage

[sv/tpp_char_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_char_decode
// Classifies one header byte as dash or hex digit and gives its digit value.
// ----------------------------------------------------------------------------
module tpp_char_decode
(
    input  logic [7:0]           char_byte,
    output tpp_pkg::char_class_t cls
);

    always_comb
    begin
        cls.is_dash = (char_byte == tpp_pkg::CH_DASH);
        cls.is_hex  = 1'b0;
        cls.digit   = 4'd0;
        if (char_byte inside {[tpp_pkg::CH_ZERO:tpp_pkg::CH_NINE]})
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(char_byte - tpp_pkg::CH_ZERO);
        end
        else if (char_byte inside {[tpp_pkg::CH_LO_A:tpp_pkg::CH_LO_F]})
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(char_byte - tpp_pkg::CH_LO_A + 8'd10);
        end
        else if (char_byte inside {[tpp_pkg::CH_UP_A:tpp_pkg::CH_UP_F]})
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(char_byte - tpp_pkg::CH_UP_A + 8'd10);
        end
    end

endmodule

[sv/tpp_field_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_field_accum
// Position counter, format checks and field accumulators; forms the result
// on the last character of a value and clears for the next one.
// ----------------------------------------------------------------------------
module tpp_field_accum
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 last,
    input  logic                 lenient_mode,
    input  tpp_pkg::char_class_t cls,
    output tpp_pkg::result_t     result
);

    logic [tpp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic        err_reg, err_next;
    logic [7:0]  ver_reg, ver_next;
    logic [63:0] trh_reg, trh_next;
    logic [63:0] trl_reg, trl_next;
    logic [63:0] par_reg, par_next;
    logic [7:0]  flg_reg, flg_next;
    logic        tnz_reg, tnz_next;
    logic        pnz_reg, pnz_next;
    logic        policy;
    logic        ok;
    logic        nz;

    always_comb
    begin
        err_next = err_reg;
        ver_next = ver_reg;
        trh_next = trh_reg;
        trl_next = trl_reg;
        par_next = par_reg;
        flg_next = flg_reg;
        tnz_next = tnz_reg;
        pnz_next = pnz_reg;
        nz       = (cls.digit != 4'd0);
        if (pos_reg >= tpp_pkg::WIRE_LEN)
        begin
            err_next = 1'b1;
        end
        else if (pos_reg inside {tpp_pkg::POS_DASH_VER, tpp_pkg::POS_DASH_TRACE,
                                 tpp_pkg::POS_DASH_PAR})
        begin
            if (!cls.is_dash)
            begin
                err_next = 1'b1;
            end
        end
        else if (!cls.is_hex)
        begin
            err_next = 1'b1;
        end
        else if (pos_reg <= tpp_pkg::POS_VER_END)
        begin
            ver_next = {ver_reg[3:0], cls.digit};
        end
        else if (pos_reg <= tpp_pkg::POS_TRH_END)
        begin
            trh_next = {trh_reg[59:0], cls.digit};
            tnz_next = tnz_reg | nz;
        end
        else if (pos_reg <= tpp_pkg::POS_TRL_END)
        begin
            trl_next = {trl_reg[59:0], cls.digit};
            tnz_next = tnz_reg | nz;
        end
        else if (pos_reg <= tpp_pkg::POS_PAR_END)
        begin
            par_next = {par_reg[59:0], cls.digit};
            pnz_next = pnz_reg | nz;
        end
        else
        begin
            flg_next = {flg_reg[3:0], cls.digit};
        end

        pos_next = (pos_reg < tpp_pkg::POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        policy = lenient_mode ? (ver_next != tpp_pkg::VER_BANNED)
                              : (ver_next == tpp_pkg::VER_STRICT);
        ok = (pos_reg == tpp_pkg::POS_LAST) && !err_next && tnz_next && pnz_next && policy;

        result.valid_res     = ok;
        result.version       = ok ? ver_next : 8'd0;
        result.trace_id_high = ok ? trh_next : 64'd0;
        result.trace_id_low  = ok ? trl_next : 64'd0;
        result.span_id       = ok ? par_next : 64'd0;
        result.flag_bits     = ok ? flg_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            err_reg <= 1'b0;
            ver_reg <= '0;
            trh_reg <= '0;
            trl_reg <= '0;
            par_reg <= '0;
            flg_reg <= '0;
            tnz_reg <= 1'b0;
            pnz_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                pos_reg <= '0;
                err_reg <= 1'b0;
                ver_reg <= '0;
                trh_reg <= '0;
                trl_reg <= '0;
                par_reg <= '0;
                flg_reg <= '0;
                tnz_reg <= 1'b0;
                pnz_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                err_reg <= err_next;
                ver_reg <= ver_next;
                trh_reg <= trh_next;
                trl_reg <= trl_next;
                par_reg <= par_next;
                flg_reg <= flg_next;
                tnz_reg <= tnz_next;
                pnz_reg <= pnz_next;
            end
        end
    end

endmodule

[sv/traceparent_header_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traceparent_header_parser_core
// Streaming parser for a trace-context header value in the version-00 layout:
// one character per beat in, one result beat per value out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | char_byte, end_of_value
//   out     | output    | out_valid / out_stall| valid_res, version, trace ids,
//           |           |                      | span_id, flag_bits
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (lenient_mode)
//
// One character per cycle while in_stall is low; a value's last character
// waits in the input register, then its result goes to the result register.
// Reset clears the position count, accumulators and lenient_mode.
// in_stall rises only while a final character waits for the result register.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module traceparent_header_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        end_of_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [7:0]  version,
    output logic [63:0] trace_id_high,
    output logic [63:0] trace_id_low,
    output logic [63:0] span_id,
    output logic [7:0]  flag_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic             in_full_reg, in_full_next;
    logic [7:0]       char_reg;
    logic             eov_reg;
    logic             out_valid_reg, out_valid_next;
    tpp_pkg::result_t res_reg;
    logic             lenient_reg;
    logic             res_free;
    logic             proc;
    logic             take;
    tpp_pkg::char_class_t cls;
    tpp_pkg::result_t     res_comb;

    tpp_char_decode u_decode
    (
        .char_byte (char_reg),
        .cls       (cls)
    );

    tpp_field_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (proc),
        .last         (eov_reg),
        .lenient_mode (lenient_reg),
        .cls          (cls),
        .result       (res_comb)
    );

    assign cfg_ready = 1'b1;
    assign res_free  = !out_valid_reg || !out_stall;
    assign proc      = in_full_reg && (!eov_reg || res_free);
    assign in_stall  = in_full_reg && !proc;
    assign take      = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (take)
        begin
            in_full_next = 1'b1;
        end
        else if (proc)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc && eov_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            lenient_reg   <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                lenient_reg <= cfg_data;
            end
        end
    end

    // hold payload until the next beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_byte;
            eov_reg  <= end_of_value;
        end
        if (proc && eov_reg)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign valid_res     = res_reg.valid_res;
    assign version       = res_reg.version;
    assign trace_id_high = res_reg.trace_id_high;
    assign trace_id_low  = res_reg.trace_id_low;
    assign span_id       = res_reg.span_id;
    assign flag_bits     = res_reg.flag_bits;

endmodule

[sv/tpp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks for the trace-context header parser, bound to the top.
// ----------------------------------------------------------------------------
module tpp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        valid_res,
    input logic [7:0]  version,
    input logic [63:0] trace_id_high,
    input logic [63:0] trace_id_low,
    input logic [63:0] span_id,
    input logic [7:0]  flag_bits
);

    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> version == 8'd0 && trace_id_high == 64'd0 &&
        trace_id_low == 64'd0 && span_id == 64'd0 && flag_bits == 8'd0)
        else $error("invalid result carries nonzero fields");

    a_ids_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> (trace_id_high != 64'd0 || trace_id_low != 64'd0) &&
        span_id != 64'd0)
        else $error("valid result with an all-zero id");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(valid_res) &&
        $stable(trace_id_high) && $stable(span_id))
        else $error("stalled result beat changed");

endmodule

bind traceparent_header_parser_core tpp_checker u_tpp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .valid_res     (valid_res),
    .version       (version),
    .trace_id_high (trace_id_high),
    .trace_id_low  (trace_id_low),
    .span_id       (span_id),
    .flag_bits     (flag_bits)
);

[bench/tb_traceparent_header_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_traceparent_header_parser_core
// Self-checking bench for the streaming trace-context header parser. Header
// values are queued as character beats, some well formed and some flawed:
// short, long, bad bytes, misplaced dashes, zero ids, and raw noise. A
// clocked driver sends them in random bursts and a monitor checks every
// result beat against a bit-accurate parser model. The receiver stalls on
// its own pattern, and there is one long hold-off. The lenient_mode register
// is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_traceparent_header_parser_core;

    typedef enum int {FLAW_NONE, FLAW_SHORT, FLAW_LONG, FLAW_BYTE, FLAW_NUL,
                      FLAW_DASH} flaw_t;
    typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} letter_case_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TARGET_CHARS  = 1350;
    localparam int TARGET_VALUES = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_byte = 8'h00;
    logic        end_of_value = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valid_res;
    logic [7:0]  version;
    logic [63:0] trace_id_high;
    logic [63:0] trace_id_low;
    logic [63:0] span_id;
    logic [7:0]  flag_bits;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    traceparent_header_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_byte     (char_byte),
        .end_of_value  (end_of_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .valid_res     (valid_res),
        .version       (version),
        .trace_id_high (trace_id_high),
        .trace_id_low  (trace_id_low),
        .span_id       (span_id),
        .flag_bits     (flag_bits),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // parser model state
    logic                      mode_lenient = 1'b0;
    logic [tpp_pkg::POS_W-1:0] pos_count = '0;
    logic                      format_bad = 1'b0;
    logic [7:0]                ver_acc = '0;
    logic [63:0]               trace_hi_acc = '0;
    logic [63:0]               trace_lo_acc = '0;
    logic [63:0]               parent_acc = '0;
    logic [7:0]                flags_acc = '0;
    logic                      trace_nonzero = 1'b0;
    logic                      parent_nonzero = 1'b0;

    char_beat_t       pending_chars [$];
    tpp_pkg::result_t expected_results [$];

    int  queued_chars = 0;
    int  chars_accepted = 0;
    int  results_checked = 0;
    int  valid_headers = 0;
    int  fail_count = 0;
    int  quiet_cycles = 0;
    int  hold_asked = 0;
    int  hold_taken = 0;
    int  hold_left = 0;
    int  stall_tick = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  mode_writes = 0;
    bit  bursty = 1'b1;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        if (c inside {[tpp_pkg::CH_ZERO:tpp_pkg::CH_NINE]})
        begin
            t = c - tpp_pkg::CH_ZERO;
            return {1'b0, t[3:0]};
        end
        if (c inside {[tpp_pkg::CH_LO_A:tpp_pkg::CH_LO_F]})
        begin
            t = c - tpp_pkg::CH_LO_A + 8'd10;
            return {1'b0, t[3:0]};
        end
        if (c inside {[tpp_pkg::CH_UP_A:tpp_pkg::CH_UP_F]})
        begin
            t = c - tpp_pkg::CH_UP_A + 8'd10;
            return {1'b0, t[3:0]};
        end
        return 5'h10;
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic [tpp_pkg::POS_W-1:0] p;
        logic [4:0]                d;
        logic                      ver_ok;
        tpp_pkg::result_t          r;
        p = pos_count;
        d = hex_digit(c);
        if (p >= tpp_pkg::WIRE_LEN)
            format_bad = 1'b1;
        else if (p inside {tpp_pkg::POS_DASH_VER, tpp_pkg::POS_DASH_TRACE,
                           tpp_pkg::POS_DASH_PAR})
        begin
            if (c != tpp_pkg::CH_DASH)
                format_bad = 1'b1;
        end
        else if (d[4])
            format_bad = 1'b1;
        else if (p <= tpp_pkg::POS_VER_END)
            ver_acc = {ver_acc[3:0], d[3:0]};
        else if (p <= tpp_pkg::POS_TRH_END)
        begin
            trace_hi_acc = {trace_hi_acc[59:0], d[3:0]};
            if (d[3:0] != 4'h0)
                trace_nonzero = 1'b1;
        end
        else if (p <= tpp_pkg::POS_TRL_END)
        begin
            trace_lo_acc = {trace_lo_acc[59:0], d[3:0]};
            if (d[3:0] != 4'h0)
                trace_nonzero = 1'b1;
        end
        else if (p <= tpp_pkg::POS_PAR_END)
        begin
            parent_acc = {parent_acc[59:0], d[3:0]};
            if (d[3:0] != 4'h0)
                parent_nonzero = 1'b1;
        end
        else
            flags_acc = {flags_acc[3:0], d[3:0]};
        if (p < tpp_pkg::POS_MAX)
            pos_count = p + 1'b1;
        if (last)
        begin
            ver_ok = mode_lenient ? (ver_acc != tpp_pkg::VER_BANNED)
                                  : (ver_acc == tpp_pkg::VER_STRICT);
            r = '0;
            if (p == tpp_pkg::POS_LAST && !format_bad && trace_nonzero && parent_nonzero &&
                ver_ok)
            begin
                r.valid_res     = 1'b1;
                r.version       = ver_acc;
                r.trace_id_high = trace_hi_acc;
                r.trace_id_low  = trace_lo_acc;
                r.span_id       = parent_acc;
                r.flag_bits     = flags_acc;
            end
            expected_results.push_back(r);
            pos_count      = '0;
            format_bad     = 1'b0;
            ver_acc        = '0;
            trace_hi_acc   = '0;
            trace_lo_acc   = '0;
            parent_acc     = '0;
            flags_acc      = '0;
            trace_nonzero  = 1'b0;
            parent_nonzero = 1'b0;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d, input letter_case_t cs);
        logic up;
        up = (cs == CASE_UPPER) || (cs == CASE_MIXED && $urandom_range(0, 1) == 1);
        if (d < 4'd10)
            return tpp_pkg::CH_ZERO + d;
        return (up ? tpp_pkg::CH_UP_A : tpp_pkg::CH_LO_A) + d - 8'd10;
    endfunction

    task automatic queue_value(input logic [7:0] ver, input logic [63:0] th,
                               input logic [63:0] tl, input logic [63:0] pid,
                               input logic [7:0] fl, input letter_case_t cs,
                               input flaw_t flaw, input int arg);
        logic [7:0] s [$];
        int         k;
        for (k = 1; k >= 0; k--)
            s.push_back(hex_char(ver[k*4 +: 4], cs));
        s.push_back(tpp_pkg::CH_DASH);
        for (k = 15; k >= 0; k--)
            s.push_back(hex_char(th[k*4 +: 4], cs));
        for (k = 15; k >= 0; k--)
            s.push_back(hex_char(tl[k*4 +: 4], cs));
        s.push_back(tpp_pkg::CH_DASH);
        for (k = 15; k >= 0; k--)
            s.push_back(hex_char(pid[k*4 +: 4], cs));
        s.push_back(tpp_pkg::CH_DASH);
        for (k = 1; k >= 0; k--)
            s.push_back(hex_char(fl[k*4 +: 4], cs));
        case (flaw)
            FLAW_SHORT: while (s.size() > arg) void'(s.pop_back());
            FLAW_LONG:  repeat (arg) s.push_back(8'($urandom_range(0, 255)));
            FLAW_BYTE:  s[arg] = 8'($urandom_range(0, 255));
            FLAW_NUL:   s[arg] = 8'h00;
            FLAW_DASH:  s[arg] = (s[arg] == tpp_pkg::CH_DASH)
                                 ? hex_char(4'($urandom_range(0, 15)), cs)
                                 : tpp_pkg::CH_DASH;
            default: ;
        endcase
        for (k = 0; k < s.size(); k++)
            pending_chars.push_back('{s[k], k == s.size() - 1});
        queued_chars += s.size();
    endtask

    function automatic logic [63:0] rand_id();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1:
            begin
                v = '0;
                v[$urandom_range(0, 15)*4 +: 4] = 4'($urandom_range(1, 15));
            end
            2: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rand_version();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return tpp_pkg::VER_STRICT;
            4:          return tpp_pkg::VER_BANNED;
            5:          return 8'hfe;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_value();
        int    r;
        int    n;
        int    k;
        int    arg;
        flaw_t f;
        r = $urandom_range(0, 99);
        if (r < 60)
            queue_value(rand_version(), rand_id(), rand_id(), rand_id(),
                        8'($urandom_range(0, 255)), letter_case_t'($urandom_range(0, 2)),
                        FLAW_NONE, 0);
        else if (r < 90)
        begin
            f = flaw_t'($urandom_range(1, 5));
            if (f == FLAW_SHORT)
                arg = $urandom_range(1, 54);
            else if (f == FLAW_LONG)
                arg = $urandom_range(1, 14);
            else
                arg = $urandom_range(0, 54);
            queue_value(rand_version(), rand_id(), rand_id(), rand_id(),
                        8'($urandom_range(0, 255)), letter_case_t'($urandom_range(0, 2)),
                        f, arg);
        end
        else
        begin
            n = $urandom_range(1, 70);
            for (k = 0; k < n; k++)
                pending_chars.push_back('{8'($urandom_range(0, 255)), k == n - 1});
            queued_chars += n;
        end
    endtask

    task automatic set_lenient(input logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        mode_lenient = m;
        mode_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] g);
        if (g !== e)
            note_failure($sformatf("result %0d %s: expected %h, got %h",
                                   results_checked, name, e, g));
    endtask

    // driver
    always @(posedge clk)
    begin
        char_beat_t beat;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_char(char_byte, end_of_value);
                chars_accepted++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    beat = pending_chars.pop_front();
                    in_valid     <= 1'b1;
                    char_byte    <= beat.ch;
                    end_of_value <= beat.last;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = bursty ? $urandom_range(1, 6) : 0;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        stall_tick++;
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case ((stall_tick / 64) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (stall_tick % 3 == 0);
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tpp_pkg::result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           results_checked));
                else
                begin
                    e = expected_results.pop_front();
                    check_field("valid_res", 64'(e.valid_res), 64'(valid_res));
                    check_field("version", 64'(e.version), 64'(version));
                    check_field("trace_id_high", e.trace_id_high, trace_id_high);
                    check_field("trace_id_low", e.trace_id_low, trace_id_low);
                    check_field("span_id", e.span_id, span_id);
                    check_field("flag_bits", 64'(e.flag_bits), 64'(flag_bits));
                    if (e.valid_res)
                        valid_headers++;
                end
                results_checked++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("timeout: %0d cycles without a beat", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        set_lenient(1'b0);
        queue_value(tpp_pkg::VER_STRICT, 64'h0af7651916cd43dd, 64'h8448eb211c80319c,
                    64'hb7ad6b7169203331, 8'h01, CASE_LOWER, FLAW_NONE, 0);
        queue_value(tpp_pkg::VER_STRICT, '1, '1, '1, 8'hff, CASE_UPPER, FLAW_NONE, 0);
        queue_value(tpp_pkg::VER_STRICT, '0, '0, 64'h1234, 8'h01, CASE_MIXED, FLAW_NONE, 0);
        queue_value(tpp_pkg::VER_STRICT, 64'h1, 64'h2, '0, 8'h00, CASE_LOWER, FLAW_NONE, 0);
        queue_value(8'h01, 64'h1, 64'h2, 64'h3, 8'h01, CASE_LOWER, FLAW_NONE, 0);
        queue_value(tpp_pkg::VER_STRICT, 64'h1, 64'h2, 64'h3, 8'h01, CASE_LOWER,
                    FLAW_SHORT, 54);
        queue_value(tpp_pkg::VER_STRICT, 64'h1, 64'h2, 64'h3, 8'h01, CASE_LOWER,
                    FLAW_LONG, 15);
        queue_value(tpp_pkg::VER_STRICT, 64'h1, 64'h2, 64'h3, 8'h01, CASE_LOWER,
                    FLAW_NUL, 10);
        queue_value(tpp_pkg::VER_STRICT, 64'h1, 64'h2, 64'h3, 8'h01, CASE_LOWER,
                    FLAW_SHORT, 1);
        queue_value(tpp_pkg::VER_STRICT, '0, 64'h1, 64'h1000000000000000, 8'h00, CASE_MIXED,
                    FLAW_NONE, 0);
        queue_value(tpp_pkg::VER_STRICT, 64'h1, 64'h2, 64'h3, 8'h01, CASE_LOWER, FLAW_DASH,
                    tpp_pkg::POS_DASH_TRACE);
        drain_results();

        set_lenient(1'b1);
        queue_value(tpp_pkg::VER_BANNED, 64'h1, 64'h2, 64'h3, 8'h01, CASE_UPPER,
                    FLAW_NONE, 0);
        queue_value(8'hfe, 64'hdead, 64'hbeef, 64'h77, 8'h80, CASE_MIXED, FLAW_NONE, 0);
        queue_value(tpp_pkg::VER_STRICT, 64'h5, 64'h6, 64'h7, 8'h03, CASE_LOWER,
                    FLAW_NONE, 0);
        queue_value(8'h42, 64'h5, 64'h6, 64'h7, 8'h03, CASE_LOWER, FLAW_LONG, 1);
        drain_results();

        phase = 0;
        while (phase < 2 || queued_chars < TARGET_CHARS || results_checked < TARGET_VALUES)
        begin
            if (phase < 2)
                set_lenient(phase[0]);
            else
                set_lenient(1'($urandom_range(0, 1)));
            bursty = (phase % 3 != 1);
            if (phase == 1)
                hold_asked++;
            n = $urandom_range(4, 8);
            repeat (n) random_value();
            drain_results();
            phase++;
        end

        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        $display("Sent %0d characters in %0d phases with %0d mode writes.",
                 chars_accepted, phase + 2, mode_writes);
        $display("Checked %0d result beats, %0d of them valid headers.",
                 results_checked, valid_headers);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
sv/tpp_pkg.sv
sv/tpp_char_decode.sv
sv/tpp_field_accum.sv
sv/traceparent_header_parser_core.sv
sv/tpp_checker.sv
bench/tb_traceparent_header_parser_core.sv
